>>> design/exp_golomb_bit_reader_defines.svh
// Assertion macros shared by the exp_golomb_bit_reader checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef EXP_GOLOMB_BIT_READER_DEFINES_SVH
`define EXP_GOLOMB_BIT_READER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/egb_pkg.sv
// Shared types and constants for the exp_golomb_bit_reader block.
// No dependencies; used by the decoder, the result buffer, the top level and the checker.
package egb_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned ZC_W       = 5;
	localparam int unsigned VAL_W      = 33;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_DATA_W = 6;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd1;

	localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SE    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RESET  = MODE_UE;
	localparam logic [CNT_W-1:0]  WIDTH_RESET = 6'd8;
	localparam logic [CNT_W-1:0]  MIN_FIELD_W = 6'd1;
	localparam logic [CNT_W-1:0]  MAX_FIELD_W = 6'd32;

	// Longest zero prefix accepted before an error result
	localparam logic [CNT_W-1:0] MAX_PREFIX_ZEROS = 6'd31;

	// How a captured value turns into code_value
	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_UE,
		KIND_SE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              err;
		logic [ZC_W-1:0]   zc;
		logic [ACC_W-1:0]  val;
	} slot_t;

	typedef slot_t [BYTE_W-1:0] slots_t;
	typedef logic [BYTE_W-1:0]  slot_mask_t;

	typedef struct packed {
		logic              go;
		logic              clear;
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  width;
	} dec_ctl_t;

endpackage

>>> design/egb_bit_decoder.sv
// Eight-step bit decoder: consumes one byte MSB first against the running code state.
// Depends on egb_pkg; emits one result slot per bit position that completes a code.
module egb_bit_decoder #(
	parameter logic [egb_pkg::CNT_W-1:0] MAX_PREFIX_ZEROS = egb_pkg::MAX_PREFIX_ZEROS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  egb_pkg::dec_ctl_t             ctl,
	input  logic [egb_pkg::BYTE_W-1:0]    byte_s1,
	output egb_pkg::slots_t               slots,
	output egb_pkg::slot_mask_t           mask
);

	typedef struct packed {
		logic [egb_pkg::ACC_W-1:0] acc;
		logic [egb_pkg::CNT_W-1:0] zc;
		logic                      insfx;
		logic [egb_pkg::CNT_W-1:0] rem;
	} dec_state_t;

	dec_state_t state_q;
	dec_state_t st;
	logic       bit_v;
	logic       fixed_mode;
	logic       signed_mode;

	assign fixed_mode  = (ctl.mode == egb_pkg::MODE_FIXED);
	assign signed_mode = (ctl.mode == egb_pkg::MODE_SE);

	always_comb begin
		st    = state_q;
		slots = '0;
		mask  = '0;
		bit_v = 1'b0;
		for (int i = 0; i < egb_pkg::BYTE_W; i++) begin
			bit_v = byte_s1[egb_pkg::BYTE_W-1-i];
			if (fixed_mode) begin
				if (!st.insfx) begin
					st.insfx = 1'b1;
					st.rem   = ctl.width;
					st.acc   = '0;
				end
				st.acc = {st.acc[egb_pkg::ACC_W-2:0], bit_v};
				st.rem = st.rem - 1'b1;
				if (st.rem == '0) begin
					mask[i]       = 1'b1;
					slots[i].kind = egb_pkg::KIND_RAW;
					slots[i].val  = st.acc;
					st            = '0;
				end
			end else if (!st.insfx) begin
				if (!bit_v) begin
					st.zc = st.zc + 1'b1;
					// prefix too long: flag it and restart at the next bit
					if (st.zc > MAX_PREFIX_ZEROS) begin
						mask[i]       = 1'b1;
						slots[i].kind = egb_pkg::KIND_RAW;
						slots[i].err  = 1'b1;
						st            = '0;
					end
				end else if (st.zc == '0) begin
					// lone one bit: code number zero
					mask[i]       = 1'b1;
					slots[i].kind = egb_pkg::KIND_RAW;
					st            = '0;
				end else begin
					st.insfx = 1'b1;
					st.rem   = st.zc;
					st.acc   = '0;
				end
			end else begin
				st.acc = {st.acc[egb_pkg::ACC_W-2:0], bit_v};
				st.rem = st.rem - 1'b1;
				if (st.rem == '0) begin
					mask[i]       = 1'b1;
					slots[i].kind = signed_mode ? egb_pkg::KIND_SE : egb_pkg::KIND_UE;
					slots[i].zc   = st.zc[egb_pkg::ZC_W-1:0];
					slots[i].val  = st.acc;
					st            = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctl.clear) begin
			state_q <= '0;
		end else if (ctl.go) begin
			state_q <= st;
		end
	end

endmodule

>>> design/egb_result_buffer.sv
// Result buffer: holds the slots of one decoded byte and sends them out one per cycle while out_stall is low.
// Depends on egb_pkg; maps raw suffix values to ue/se code values in front of the output register.
module egb_result_buffer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  egb_pkg::slots_t                   slots_in,
	input  egb_pkg::slot_mask_t               mask_in,
	output logic                              free,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [egb_pkg::VAL_W-1:0]  code_value,
	output logic                              prefix_error,
	output logic                              last_of_byte
);

	localparam logic [egb_pkg::VAL_W-1:0] ONE_V = {{(egb_pkg::VAL_W-1){1'b0}}, 1'b1};

	egb_pkg::slots_t      slots_s2;
	egb_pkg::slot_mask_t  mask_s2;
	egb_pkg::slot_mask_t  pick;
	egb_pkg::slot_mask_t  rest;
	egb_pkg::slot_t       sel;
	logic                 busy;
	logic                 last;
	logic                 out_ready;
	logic                 pop;

	logic                             out_valid_q;
	logic signed [egb_pkg::VAL_W-1:0] code_value_q;
	logic                             prefix_error_q;
	logic                             last_of_byte_q;

	function automatic logic [egb_pkg::VAL_W-1:0] finish_value(egb_pkg::slot_t s);
		logic [egb_pkg::VAL_W-1:0] cn_p1;
		logic [egb_pkg::VAL_W-1:0] mag;
		logic [egb_pkg::VAL_W-1:0] res;
		// suffix is below 2^zc, so codeNum + 1 is the suffix with a leading one
		cn_p1 = (ONE_V << s.zc) | {1'b0, s.val};
		mag   = cn_p1 >> 1;
		case (s.kind)
			egb_pkg::KIND_UE: res = cn_p1 - ONE_V;
			// codeNum is even exactly when the suffix is odd
			egb_pkg::KIND_SE: res = s.val[0] ? (~mag + ONE_V) : mag;
			default:          res = {1'b0, s.val};
		endcase
		return res;
	endfunction

	assign busy      = |mask_s2;
	assign pick      = mask_s2 & (~mask_s2 + 1'b1);
	assign rest      = mask_s2 & ~pick;
	assign last      = (rest == '0);
	assign out_ready = !out_valid_q || !out_stall;
	assign pop       = busy && out_ready;
	assign free      = !busy || (pop && last);

	always_comb begin
		sel = '0;
		for (int i = 0; i < egb_pkg::BYTE_W; i++) begin
			if (pick[i]) begin
				sel = slots_s2[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (load) begin
			mask_s2 <= mask_in;
		end else if (pop) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_s2 <= slots_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_value_q   <= finish_value(sel);
			prefix_error_q <= sel.err;
			last_of_byte_q <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign code_value   = code_value_q;
	assign prefix_error = prefix_error_q;
	assign last_of_byte = last_of_byte_q;

endmodule

>>> design/exp_golomb_bit_reader.sv
// Path: an accepted byte is registered in byte_s1, its slots in the result buffer,
// each result in the output register; results of one byte follow without gaps while
// out_stall is low. Throughput: one byte per cycle while each byte completes at most
// one code and out_stall is low; more codes hold the buffer (one output register port).
// Reset: decode_mode 1 (ue), field_width 8, code state cleared, no result pending.
// Depends on egb_pkg, egb_bit_decoder and egb_result_buffer.
module exp_golomb_bit_reader #(
	parameter logic [egb_pkg::CNT_W-1:0] MAX_PREFIX_ZEROS = egb_pkg::MAX_PREFIX_ZEROS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [egb_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [egb_pkg::CFG_DATA_W-1:0]       wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [egb_pkg::BYTE_W-1:0]           data_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [egb_pkg::VAL_W-1:0]     code_value,
	output logic                                 prefix_error,
	output logic                                 last_of_byte
);

	logic [egb_pkg::MODE_W-1:0] mode_q;
	logic [egb_pkg::CNT_W-1:0]  width_q;
	logic [egb_pkg::CNT_W-1:0]  width_eff;
	logic                       valid_s1;
	logic [egb_pkg::BYTE_W-1:0] byte_s1;
	logic                       buf_free;
	egb_pkg::dec_ctl_t          dec_ctl;
	egb_pkg::slots_t            dec_slots;
	egb_pkg::slot_mask_t        dec_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= egb_pkg::MODE_RESET;
			width_q <= egb_pkg::WIDTH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				egb_pkg::REG_DECODE_MODE: mode_q  <= wr_data[egb_pkg::MODE_W-1:0];
				egb_pkg::REG_FIELD_WIDTH: width_q <= wr_data;
				default: ;
			endcase
		end
	end

	// clamp the field width into 1..32
	always_comb begin
		if (width_q < egb_pkg::MIN_FIELD_W) begin
			width_eff = egb_pkg::MIN_FIELD_W;
		end else if (width_q > egb_pkg::MAX_FIELD_W) begin
			width_eff = egb_pkg::MAX_FIELD_W;
		end else begin
			width_eff = width_q;
		end
	end

	assign in_stall = valid_s1 && !buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_comb begin
		dec_ctl.go    = valid_s1 && buf_free;
		dec_ctl.clear = wr_en && (wr_index == egb_pkg::REG_DECODE_MODE ||
			wr_index == egb_pkg::REG_FIELD_WIDTH);
		dec_ctl.mode  = mode_q;
		dec_ctl.width = width_eff;
	end

	egb_bit_decoder #(
		.MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dec_ctl),
		.byte_s1 (byte_s1),
		.slots   (dec_slots),
		.mask    (dec_mask)
	);

	egb_result_buffer u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (dec_ctl.go),
		.slots_in     (dec_slots),
		.mask_in      (dec_mask),
		.free         (buf_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_value   (code_value),
		.prefix_error (prefix_error),
		.last_of_byte (last_of_byte)
	);

endmodule

>>> design/egb_checker.sv
// Port-level checker for exp_golomb_bit_reader, attached by bind.
// Depends on egb_pkg and exp_golomb_bit_reader_defines.svh.
`include "exp_golomb_bit_reader_defines.svh"

module egb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [egb_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [egb_pkg::CFG_DATA_W-1:0]       wr_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [egb_pkg::BYTE_W-1:0]           data_byte,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [egb_pkg::VAL_W-1:0]     code_value,
	input  logic                                 prefix_error,
	input  logic                                 last_of_byte
);

	logic [egb_pkg::MODE_W-1:0] mode_q;

	// track the mode register from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= egb_pkg::MODE_RESET;
		end else if (wr_en && wr_index == egb_pkg::REG_DECODE_MODE) begin
			mode_q <= wr_data[egb_pkg::MODE_W-1:0];
		end
	end

	`EGB_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		in_valid && $stable(data_byte), "stalled request changed")
	`EGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(code_value) && $stable(prefix_error) && $stable(last_of_byte),
		"stalled result changed")
	`EGB_ASSERT_NOW(a_err_zero, out_valid && prefix_error, code_value == '0,
		"error result with nonzero value")
	`EGB_ASSERT_NOW(a_sign_mode, out_valid && code_value[egb_pkg::VAL_W-1],
		mode_q == egb_pkg::MODE_SE, "negative value outside signed mode")
	`EGB_ASSERT_NEXT(a_burst, out_valid && !out_stall && !last_of_byte, out_valid,
		"gap inside the results of one byte")

endmodule

bind exp_golomb_bit_reader egb_checker u_egb_checker (.*);
